// ----- src/tsg_pkg.sv -----
// Shared types and constants for the tree split gain block.
// No dependencies; used by tree_split_gain.
`timescale 1ns / 1ps

package tsg_pkg;

   // Sequencer states of the gain engine
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_MUL,
      ST_DIV,
      ST_DONE
   } seq_state_type;

   // Register file: index = paddr[3:2]
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam logic [1:0] REG_SPLIT_THRESHOLD = 2'd0;
   localparam logic [1:0] REG_COMPARE_MODE    = 2'd1;
   localparam logic [1:0] REG_RIDGE_LAMBDA    = 2'd2;

   localparam logic [31:0] RIDGE_LAMBDA_RESET = 32'h0001_0000;

   // Field widths
   localparam int VALUE_W    = 32;
   localparam int GAIN_W     = 64;
   localparam int COUNT_W    = 17;
   localparam int FRAC_SHIFT = 16;
   localparam int REQ_DATA_W = 64;
   localparam int RSP_FIELD_W = GAIN_W + 2 * COUNT_W;
   localparam int RSP_DATA_W  = ((RSP_FIELD_W + 7) / 8) * 8;
   localparam int RSP_PAD_W   = RSP_DATA_W - RSP_FIELD_W;

endpackage

// ----- src/tree_split_gain.sv -----
// Split gain for one feature column of a least-squares boosted tree.
// Depends on tsg_pkg.
`timescale 1ns / 1ps

// Samples are taken one per clock while req_tready is high and are sorted
// left or right of split_threshold (below it, or equal to it in categorical
// mode) into per-side counts and gradient sums. A transfer with tlast set
// starts the gain engine: for each side it forms sum^2 by shift-add and
// divides sum^2*2^16 by count*2^16 + ridge_lambda with a restoring divider
// at one quotient bit per cycle. A last sample therefore holds the input
// off until the result is loaded into the output register; when one side
// is empty the multiply and divide are skipped. The result waits in an
// output register; the block only stalls at the end of the engine run if
// the previous result has not been taken. The gain is unsigned Q32.32 and
// saturates at all ones. Samples beyond MAX_SAMPLES in one column are
// dropped from the sums.
module tree_split_gain #(
   parameter int MAX_SAMPLES = 65536
) (
   input  logic                                clock,
   input  logic                                reset,
   // sample stream
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [tsg_pkg::REQ_DATA_W-1:0]      req_tdata,  // sample_value, gradient
   input  logic                                req_tlast,  // last
   // result stream
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [tsg_pkg::RSP_DATA_W-1:0]      rsp_tdata,  // gain, left_count, right_count
   output logic                                rsp_tuser,  // split_valid
   // register port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [tsg_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [tsg_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [tsg_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);

   localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
   localparam int SUM_W  = tsg_pkg::VALUE_W + $clog2(MAX_SAMPLES);
   localparam int DIV_W  = 2 * SUM_W + tsg_pkg::FRAC_SHIFT;
   localparam int STEP_W = $clog2(DIV_W);
   localparam int DEN_BASE_W = (CNT_W + tsg_pkg::FRAC_SHIFT > tsg_pkg::VALUE_W) ?
                               CNT_W + tsg_pkg::FRAC_SHIFT : tsg_pkg::VALUE_W;
   localparam int DEN_W  = DEN_BASE_W + 1;

   // configuration
   logic signed [31:0]  threshold_ff;
   logic                mode_ff;
   logic [31:0]         lambda_ff;

   // accumulators
   logic [CNT_W-1:0]    left_tally_ff, left_tally_in;
   logic [CNT_W-1:0]    right_tally_ff, right_tally_in;
   logic [SUM_W-1:0]    left_sum_ff, left_sum_in;
   logic [SUM_W-1:0]    right_sum_ff, right_sum_in;

   // engine
   tsg_pkg::seq_state_type state_ff, state_in;
   logic                side_ff, side_in;
   logic [SUM_W-1:0]    mag_ff, mag_in;
   logic [SUM_W-1:0]    bits_ff, bits_in;
   logic [DIV_W-1:0]    work_ff, work_in;
   logic [DEN_W-1:0]    den_ff, den_in;
   logic [DEN_W-1:0]    rem_ff, rem_in;
   logic [tsg_pkg::GAIN_W-1:0] quot_ff, quot_in;
   logic                sat_ff, sat_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [tsg_pkg::GAIN_W-1:0] gain_acc_ff, gain_acc_in;
   logic                split_ok_ff, split_ok_in;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [tsg_pkg::GAIN_W-1:0]  rsp_gain_ff, rsp_gain_in;
   logic [tsg_pkg::COUNT_W-1:0] rsp_left_ff, rsp_left_in;
   logic [tsg_pkg::COUNT_W-1:0] rsp_right_ff, rsp_right_in;
   logic                rsp_ok_ff, rsp_ok_in;

   // combinational helpers
   logic                req_xfer;
   logic                out_free;
   logic                both_sides;
   logic signed [31:0]  sample_value;
   logic [31:0]         gradient;
   logic [SUM_W-1:0]    grad_ext;
   logic                go_left;
   logic [CNT_W-1:0]    total;
   logic [SUM_W-1:0]    side_sum;
   logic [CNT_W-1:0]    side_tally;
   logic [SUM_W-1:0]    side_mag;
   logic [DIV_W-1:0]    prod_next;
   logic [DEN_W:0]      trial;
   logic                qbit;
   logic [DEN_W-1:0]    rem_next;
   logic [tsg_pkg::GAIN_W-1:0] quot_next;
   logic                sat_next;
   logic [tsg_pkg::GAIN_W-1:0] side_gain;
   logic [tsg_pkg::GAIN_W:0]   gain_sum;
   logic                csr_write;

   assign sample_value = req_tdata[31:0];
   assign gradient     = req_tdata[63:32];
   assign grad_ext     = {{(SUM_W - tsg_pkg::VALUE_W){gradient[31]}}, gradient};
   assign go_left      = mode_ff ? (sample_value == threshold_ff)
                                 : (sample_value < threshold_ff);
   assign total        = left_tally_ff + right_tally_ff;
   assign req_xfer     = req_tvalid && req_tready;
   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign both_sides   = (left_tally_ff != '0) && (right_tally_ff != '0);

   assign side_sum   = side_ff ? right_sum_ff : left_sum_ff;
   assign side_tally = side_ff ? right_tally_ff : left_tally_ff;
   assign side_mag   = side_sum[SUM_W-1] ? (~side_sum + 1'b1) : side_sum;

   // shift-add square, MSB of the multiplier first
   assign prod_next = (work_ff << 1) + (bits_ff[SUM_W-1] ? DIV_W'(mag_ff) : '0);

   // restoring divide step
   assign trial     = {rem_ff, work_ff[DIV_W-1]};
   assign qbit      = trial >= {1'b0, den_ff};
   assign rem_next  = qbit ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
   assign quot_next = {quot_ff[tsg_pkg::GAIN_W-2:0], qbit};
   assign sat_next  = sat_ff || (qbit && (step_ff >= STEP_W'(tsg_pkg::GAIN_W)));
   assign side_gain = sat_next ? '1 : quot_next;
   assign gain_sum  = {1'b0, gain_acc_ff} + {1'b0, side_gain};

   // ---------------- sequencer: next state ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tsg_pkg::ST_IDLE: begin
            if (req_xfer && req_tlast) state_in = tsg_pkg::ST_LOAD;
         end
         tsg_pkg::ST_LOAD: begin
            if (!side_ff && !both_sides) state_in = tsg_pkg::ST_DONE;
            else state_in = tsg_pkg::ST_MUL;
         end
         tsg_pkg::ST_MUL: begin
            if (step_ff == '0) state_in = tsg_pkg::ST_DIV;
         end
         tsg_pkg::ST_DIV: begin
            if (step_ff == '0) state_in = side_ff ? tsg_pkg::ST_DONE : tsg_pkg::ST_LOAD;
         end
         tsg_pkg::ST_DONE: begin
            if (out_free) state_in = tsg_pkg::ST_IDLE;
         end
         default: state_in = tsg_pkg::ST_IDLE;
      endcase
   end

   // ---------------- sequencer: outputs ----------------
   always_comb begin
      req_tready = 1'b0;
      case (state_ff)
         tsg_pkg::ST_IDLE: req_tready = 1'b1;
         default:          req_tready = 1'b0;
      endcase
   end

   // ---------------- datapath next values ----------------
   always_comb begin
      left_tally_in  = left_tally_ff;
      right_tally_in = right_tally_ff;
      left_sum_in    = left_sum_ff;
      right_sum_in   = right_sum_ff;
      side_in        = side_ff;
      mag_in         = mag_ff;
      bits_in        = bits_ff;
      work_in        = work_ff;
      den_in         = den_ff;
      rem_in         = rem_ff;
      quot_in        = quot_ff;
      sat_in         = sat_ff;
      step_in        = step_ff;
      gain_acc_in    = gain_acc_ff;
      split_ok_in    = split_ok_ff;
      rsp_gain_in    = rsp_gain_ff;
      rsp_left_in    = rsp_left_ff;
      rsp_right_in   = rsp_right_ff;
      rsp_ok_in      = rsp_ok_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;

      case (state_ff)
         tsg_pkg::ST_IDLE: begin
            // samples past the column limit are dropped
            if (req_xfer && (total < CNT_W'(MAX_SAMPLES))) begin
               if (go_left) begin
                  left_tally_in = left_tally_ff + 1'b1;
                  left_sum_in   = left_sum_ff + grad_ext;
               end else begin
                  right_tally_in = right_tally_ff + 1'b1;
                  right_sum_in   = right_sum_ff + grad_ext;
               end
            end
         end
         tsg_pkg::ST_LOAD: begin
            mag_in  = side_mag;
            bits_in = side_mag;
            work_in = '0;
            den_in  = DEN_W'({side_tally, {tsg_pkg::FRAC_SHIFT{1'b0}}}) + DEN_W'(lambda_ff);
            rem_in  = '0;
            quot_in = '0;
            sat_in  = 1'b0;
            step_in = STEP_W'(SUM_W - 1);
            if (!side_ff) begin
               gain_acc_in = '0;
               split_ok_in = both_sides;
            end
         end
         tsg_pkg::ST_MUL: begin
            bits_in = bits_ff << 1;
            step_in = step_ff - 1'b1;
            work_in = prod_next;
            if (step_ff == '0) begin
               work_in = prod_next << tsg_pkg::FRAC_SHIFT;
               step_in = STEP_W'(DIV_W - 1);
            end
         end
         tsg_pkg::ST_DIV: begin
            work_in = work_ff << 1;
            rem_in  = rem_next;
            quot_in = quot_next;
            sat_in  = sat_next;
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               gain_acc_in = gain_sum[tsg_pkg::GAIN_W] ? '1 : gain_sum[tsg_pkg::GAIN_W-1:0];
               side_in     = !side_ff;
            end
         end
         tsg_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_gain_in    = split_ok_ff ? gain_acc_ff : '0;
               rsp_left_in    = tsg_pkg::COUNT_W'(left_tally_ff);
               rsp_right_in   = tsg_pkg::COUNT_W'(right_tally_ff);
               rsp_ok_in      = split_ok_ff;
               left_tally_in  = '0;
               right_tally_in = '0;
               left_sum_in    = '0;
               right_sum_in   = '0;
               side_in        = 1'b0;
            end
         end
         default: begin
            side_in = 1'b0;
         end
      endcase
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= tsg_pkg::ST_IDLE;
         side_ff        <= 1'b0;
         left_tally_ff  <= '0;
         right_tally_ff <= '0;
         left_sum_ff    <= '0;
         right_sum_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         side_ff        <= side_in;
         left_tally_ff  <= left_tally_in;
         right_tally_ff <= right_tally_in;
         left_sum_ff    <= left_sum_in;
         right_sum_ff   <= right_sum_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff       <= mag_in;
      bits_ff      <= bits_in;
      work_ff      <= work_in;
      den_ff       <= den_in;
      rem_ff       <= rem_in;
      quot_ff      <= quot_in;
      sat_ff       <= sat_in;
      step_ff      <= step_in;
      gain_acc_ff  <= gain_acc_in;
      split_ok_ff  <= split_ok_in;
      rsp_gain_ff  <= rsp_gain_in;
      rsp_left_ff  <= rsp_left_in;
      rsp_right_ff <= rsp_right_in;
      rsp_ok_ff    <= rsp_ok_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{tsg_pkg::RSP_PAD_W{1'b0}}, rsp_right_ff, rsp_left_ff, rsp_gain_ff};
   assign rsp_tuser  = rsp_ok_ff;

   // ---------------- register port ----------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= '0;
         mode_ff      <= 1'b0;
         lambda_ff    <= tsg_pkg::RIDGE_LAMBDA_RESET;
      end else if (csr_write) begin
         case (csr_paddr[3:2])
            tsg_pkg::REG_SPLIT_THRESHOLD: threshold_ff <= csr_pwdata;
            tsg_pkg::REG_COMPARE_MODE:    mode_ff      <= csr_pwdata[0];
            tsg_pkg::REG_RIDGE_LAMBDA:    lambda_ff    <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         tsg_pkg::REG_SPLIT_THRESHOLD: csr_prdata = threshold_ff;
         tsg_pkg::REG_COMPARE_MODE:    csr_prdata = {31'b0, mode_ff};
         tsg_pkg::REG_RIDGE_LAMBDA:    csr_prdata = lambda_ff;
         default:                      csr_prdata = '0;
      endcase
   end

endmodule
